// ----- src/trail_stamp_resampler_top_assert.svh -----
// assertion macros of the resampler, used by the back end
`ifndef TRAIL_STAMP_RESAMPLER_TOP_ASSERT_SVH
`define TRAIL_STAMP_RESAMPLER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/tsr_pkg.sv -----
// shared types, constants and tables of the trail stamp resampler
`default_nettype none
package tsr_pkg;

   localparam int MAX_STEPS    = 64;
   localparam int STEP_W       = 7;
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = 4;
   localparam int CX_W         = 28;
   localparam int CZ_W         = 21;
   localparam int ANGLE_W      = 15;
   localparam int ANGLE_LIMIT  = 12868;
   localparam int HALF_PI_Q16  = 102944;
   localparam int DIV_W        = 18;
   localparam int DEN_W        = 8;
   localparam int D2_W         = 33;
   localparam int MAG_W        = 17;

   typedef struct packed {
      logic                first;
      logic signed [15:0]  base_x;
      logic signed [15:0]  base_y;
      logic signed [16:0]  dx;
      logic signed [16:0]  dy;
      logic [D2_W-1:0]     d2;
   } cmd_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [DEN_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_W-1:0]   quot;
      logic [DEN_W-1:0]   rem;
   } div_rsp_type;

   // round(atan(2^-i) * 65536)
   function automatic logic [CZ_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [CZ_W-1:0] v;
      unique case (idx)
         4'd0:    v = 21'd51472;
         4'd1:    v = 21'd30386;
         4'd2:    v = 21'd16055;
         4'd3:    v = 21'd8150;
         4'd4:    v = 21'd4091;
         4'd5:    v = 21'd2047;
         4'd6:    v = 21'd1024;
         4'd7:    v = 21'd512;
         4'd8:    v = 21'd256;
         4'd9:    v = 21'd128;
         4'd10:   v = 21'd64;
         4'd11:   v = 21'd32;
         4'd12:   v = 21'd16;
         4'd13:   v = 21'd8;
         4'd14:   v = 21'd4;
         4'd15:   v = 21'd2;
         default: v = 21'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- src/tsr_front.sv -----
// front end: accepts positions, measures the move and classifies it
`default_nettype none
module tsr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic signed [15:0]    point_x,
   input  wire logic signed [15:0]    point_y,
   input  wire logic [15:0]           min_dist,
   input  wire logic                  q_full,
   output logic                       q_push,
   output tsr_pkg::cmd_type           q_data
);

   typedef enum logic [2:0] {F_IDLE, F_SQX, F_SQY, F_MM, F_DEC, F_PUSH} front_state_type;

   front_state_type                state_ff;
   logic                           have_prev_ff;
   logic signed [15:0]             prev_x_ff, prev_y_ff;
   logic signed [15:0]             new_x_ff, new_y_ff;
   logic signed [16:0]             dx_ff, dy_ff;
   logic [tsr_pkg::D2_W-1:0]       acc_ff;
   logic [31:0]                    sq_ff;
   logic [31:0]                    mm_ff;
   logic [16:0]                    absx_wide, absy_wide;
   logic [15:0]                    absx, absy;

   assign absx_wide = dx_ff[16] ? 17'(-dx_ff) : 17'(dx_ff);
   assign absy_wide = dy_ff[16] ? 17'(-dy_ff) : 17'(dy_ff);
   assign absx      = absx_wide[15:0];
   assign absy      = absy_wide[15:0];

   assign req_full = (state_ff != F_IDLE);
   assign q_push   = (state_ff == F_PUSH) && !q_full;

   always_comb begin
      q_data.first  = !have_prev_ff;
      q_data.base_x = have_prev_ff ? prev_x_ff : new_x_ff;
      q_data.base_y = have_prev_ff ? prev_y_ff : new_y_ff;
      q_data.dx     = dx_ff;
      q_data.dy     = dy_ff;
      q_data.d2     = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_push) begin
                  new_x_ff <= point_x;
                  new_y_ff <= point_y;
                  dx_ff    <= 17'(point_x) - 17'(prev_x_ff);
                  dy_ff    <= 17'(point_y) - 17'(prev_y_ff);
                  state_ff <= have_prev_ff ? F_SQX : F_PUSH;
               end
            end
            F_SQX: begin
               acc_ff   <= {1'b0, 32'(absx) * 32'(absx)};
               state_ff <= F_SQY;
            end
            F_SQY: begin
               sq_ff    <= 32'(absy) * 32'(absy);
               state_ff <= F_MM;
            end
            F_MM: begin
               acc_ff   <= acc_ff + {1'b0, sq_ff};
               mm_ff    <= 32'(min_dist) * 32'(min_dist);
               state_ff <= F_DEC;
            end
            F_DEC: begin
               // shorter than the spacing: dropped, stored point kept
               state_ff <= (acc_ff < {1'b0, mm_ff}) ? F_IDLE : F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  prev_x_ff    <= new_x_ff;
                  prev_y_ff    <= new_y_ff;
                  have_prev_ff <= 1'b1;
                  state_ff     <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- src/tsr_cmd_queue.sv -----
// two-entry command queue between front and back
`default_nettype none
module tsr_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tsr_pkg::cmd_type  push_data,
   output logic                   full,
   input  wire logic              pop,
   output tsr_pkg::cmd_type       pop_data,
   output logic                   empty
);

   tsr_pkg::cmd_type  slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule
`default_nettype wire

// ----- src/tsr_divider.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module tsr_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tsr_pkg::div_req_type  req,
   output tsr_pkg::div_rsp_type       rsp
);

   logic                          busy_ff, done_ff;
   logic [4:0]                    cnt_ff;
   logic [tsr_pkg::DIV_W-1:0]     num_ff;
   logic [tsr_pkg::DEN_W-1:0]     rem_ff, den_ff;
   logic [tsr_pkg::DEN_W:0]       trial, diff;
   logic                          fits;

   assign trial = {rem_ff, num_ff[tsr_pkg::DIV_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;
   assign rsp.rem  = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(tsr_pkg::DIV_W - 1);
            num_ff  <= req.dividend;
            den_ff  <= req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[tsr_pkg::DEN_W-1:0] : trial[tsr_pkg::DEN_W-1:0];
            num_ff <= {num_ff[tsr_pkg::DIV_W-2:0], fits};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/tsr_back.sv -----
// back end: step count, travel angle and stamp emission
`default_nettype none
`include "trail_stamp_resampler_top_assert.svh"
module tsr_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           min_dist,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   input  wire tsr_pkg::cmd_type      q_data,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output logic signed [15:0]         stamp_x,
   output logic signed [15:0]         stamp_y,
   output logic signed [14:0]         stamp_angle,
   output logic                       last_of_run
);

   typedef enum logic [3:0] {
      B_IDLE, B_FIRST, B_MUL1, B_MUL2, B_CMP, B_CORD,
      B_DIVX, B_WAITX, B_DIVY, B_WAITY, B_EMIT
   } back_state_type;

   localparam int CX = tsr_pkg::CX_W;
   localparam int CZ = tsr_pkg::CZ_W;
   localparam int SW = tsr_pkg::STEP_W;
   localparam int MW = tsr_pkg::MAG_W;
   localparam int DW = tsr_pkg::DEN_W;

   back_state_type               state_ff;
   tsr_pkg::cmd_type             cmd_ff;
   logic [SW-1:0]                s_ff, i_ff;
   logic [2:0]                   bit_ff;
   logic [22:0]                  prod_ff;
   logic [45:0]                  sq_ff;
   logic signed [CX-1:0]         cx_ff, cy_ff;
   logic signed [CZ-1:0]         cz_ff;
   logic [tsr_pkg::ITER_W-1:0]   iter_ff;
   logic signed [14:0]           angle_ff;
   logic [MW-1:0]                qx_ff, qy_ff, qax_ff, qay_ff;
   logic [DW-1:0]                rx_ff, ry_ff, rax_ff, ray_ff;
   logic                         out_valid_ff;
   logic signed [15:0]           out_x_ff, out_y_ff;
   logic signed [14:0]           out_a_ff;
   logic                         out_last_ff;

   tsr_pkg::div_req_type         div_req;
   tsr_pkg::div_rsp_type         div_rsp;

   logic                         load_ok;
   logic                         out_load;
   logic [SW-1:0]                cand;
   logic [DW-1:0]                two_s;
   logic [MW-1:0]                absx, absy;
   logic signed [CX-1:0]         x0, y0, xs, ys;
   logic signed [CZ-1:0]         z_step;
   logic signed [CZ:0]           z_round;
   logic signed [CZ-4:0]         z_q12;
   logic signed [14:0]           angle_next;
   logic [DW:0]                  sum_x, sum_y;
   logic [MW-1:0]                qx_next, qy_next;
   logic [DW-1:0]                rx_next, ry_next;
   logic signed [17:0]           off_x, off_y, pos_x, pos_y;

   tsr_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign load_ok   = !out_valid_ff || rsp_pop;
   assign out_load  = ((state_ff == B_FIRST) || (state_ff == B_EMIT)) && load_ok;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign stamp_x     = out_x_ff;
   assign stamp_y     = out_y_ff;
   assign stamp_angle = out_a_ff;
   assign last_of_run = out_last_ff;

   assign cand  = s_ff | SW'(1 << bit_ff);
   assign two_s = {s_ff, 1'b0};
   assign absx  = cmd_ff.dx[16] ? MW'(-cmd_ff.dx) : MW'(cmd_ff.dx);
   assign absy  = cmd_ff.dy[16] ? MW'(-cmd_ff.dy) : MW'(cmd_ff.dy);

   // cordic operands scaled by 256
   assign x0 = CX'(cmd_ff.dx) <<< 8;
   assign y0 = CX'(cmd_ff.dy) <<< 8;
   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;
   assign z_step = CZ'(tsr_pkg::atan_entry(iter_ff));

   // final angle, rounded to q3.12 and clamped
   assign z_round = (CZ+1)'(cz_ff) + (CZ+1)'(8);
   assign z_q12   = z_round[CZ:4];
   always_comb begin
      if (z_q12 > (CZ-3)'(tsr_pkg::ANGLE_LIMIT)) begin
         angle_next = 15'(tsr_pkg::ANGLE_LIMIT);
      end else if (z_q12 < -(CZ-3)'(tsr_pkg::ANGLE_LIMIT)) begin
         angle_next = -15'(tsr_pkg::ANGLE_LIMIT);
      end else begin
         angle_next = z_q12[14:0];
      end
   end

   // incremental quotient of (2|d|i + s) / 2s
   always_comb begin
      sum_x = {1'b0, rx_ff} + {1'b0, rax_ff};
      sum_y = {1'b0, ry_ff} + {1'b0, ray_ff};
      if (sum_x >= {1'b0, two_s}) begin
         rx_next = DW'(sum_x - {1'b0, two_s});
         qx_next = qx_ff + qax_ff + MW'(1);
      end else begin
         rx_next = sum_x[DW-1:0];
         qx_next = qx_ff + qax_ff;
      end
      if (sum_y >= {1'b0, two_s}) begin
         ry_next = DW'(sum_y - {1'b0, two_s});
         qy_next = qy_ff + qay_ff + MW'(1);
      end else begin
         ry_next = sum_y[DW-1:0];
         qy_next = qy_ff + qay_ff;
      end
      off_x = cmd_ff.dx[16] ? -18'(qx_next) : 18'(qx_next);
      off_y = cmd_ff.dy[16] ? -18'(qy_next) : 18'(qy_next);
      pos_x = 18'(cmd_ff.base_x) + off_x;
      pos_y = 18'(cmd_ff.base_y) + off_y;
   end

   always_comb begin
      div_req.start    = (state_ff == B_DIVX) || (state_ff == B_DIVY);
      div_req.dividend = (state_ff == B_DIVY) ? {absy, 1'b0} : {absx, 1'b0};
      div_req.divisor  = two_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  cmd_ff   <= q_data;
                  s_ff     <= '0;
                  bit_ff   <= 3'(SW - 1);
                  state_ff <= q_data.first ? B_FIRST : B_MUL1;
               end
            end
            B_FIRST: begin
               if (load_ok) begin
                  out_x_ff     <= cmd_ff.base_x;
                  out_y_ff     <= cmd_ff.base_y;
                  out_a_ff     <= '0;
                  out_last_ff  <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            B_MUL1: begin
               prod_ff  <= 23'(cand) * 23'(min_dist);
               state_ff <= B_MUL2;
            end
            B_MUL2: begin
               sq_ff    <= 46'(prod_ff) * 46'(prod_ff);
               state_ff <= B_CMP;
            end
            B_CMP: begin
               if (cand <= SW'(tsr_pkg::MAX_STEPS) && sq_ff <= 46'(cmd_ff.d2)) begin
                  s_ff <= cand;
               end
               if (bit_ff == 3'd0) begin
                  // quarter-turn into the right half plane
                  if (x0 < 0) begin
                     if (y0 >= 0) begin
                        cx_ff <= y0;
                        cy_ff <= -x0;
                        cz_ff <= CZ'(tsr_pkg::HALF_PI_Q16);
                     end else begin
                        cx_ff <= -y0;
                        cy_ff <= x0;
                        cz_ff <= -CZ'(tsr_pkg::HALF_PI_Q16);
                     end
                  end else begin
                     cx_ff <= x0;
                     cy_ff <= y0;
                     cz_ff <= '0;
                  end
                  iter_ff  <= '0;
                  state_ff <= B_CORD;
               end else begin
                  bit_ff   <= bit_ff - 3'd1;
                  state_ff <= B_MUL1;
               end
            end
            B_CORD: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + z_step;
               end else if (cy_ff < 0) begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - z_step;
               end
               iter_ff <= iter_ff + tsr_pkg::ITER_W'(1);
               if (iter_ff == tsr_pkg::ITER_W'(tsr_pkg::CORDIC_ITERS - 1)) begin
                  state_ff <= B_DIVX;
               end
            end
            B_DIVX: begin
               angle_ff <= angle_next;
               state_ff <= B_WAITX;
            end
            B_WAITX: begin
               if (div_rsp.done) begin
                  qax_ff   <= div_rsp.quot[MW-1:0];
                  rax_ff   <= div_rsp.rem;
                  state_ff <= B_DIVY;
               end
            end
            B_DIVY: begin
               state_ff <= B_WAITY;
            end
            B_WAITY: begin
               if (div_rsp.done) begin
                  qay_ff   <= div_rsp.quot[MW-1:0];
                  ray_ff   <= div_rsp.rem;
                  qx_ff    <= '0;
                  qy_ff    <= '0;
                  rx_ff    <= DW'(s_ff);
                  ry_ff    <= DW'(s_ff);
                  i_ff     <= SW'(1);
                  state_ff <= B_EMIT;
               end
            end
            B_EMIT: begin
               if (load_ok) begin
                  out_x_ff     <= pos_x[15:0];
                  out_y_ff     <= pos_y[15:0];
                  out_a_ff     <= angle_ff;
                  out_last_ff  <= (i_ff == s_ff);
                  qx_ff        <= qx_next;
                  qy_ff        <= qy_next;
                  rx_ff        <= rx_next;
                  ry_ff        <= ry_next;
                  i_ff         <= i_ff + SW'(1);
                  if (i_ff == s_ff) begin
                     state_ff <= B_IDLE;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   `TSR_ASSERT_IMPLY(a_emit_range, clock, reset, state_ff == B_EMIT,
      i_ff >= SW'(1) && i_ff <= s_ff && s_ff <= SW'(tsr_pkg::MAX_STEPS), "stamp index out of range")
   `TSR_ASSERT_IMPLY(a_rem_bound, clock, reset, state_ff == B_EMIT,
      rx_ff < two_s && ry_ff < two_s, "interpolation remainder not below divisor")
   `TSR_ASSERT_NEXT(a_run_end, clock, reset, state_ff == B_EMIT && load_ok && i_ff == s_ff,
      state_ff == B_IDLE && out_valid_ff && out_last_ff, "final stamp not marked")

endmodule
`default_nettype wire

// ----- src/trail_stamp_resampler_top.sv -----
// top level of the trail stamp resampler
// usage:
//  - requests (positions) enter on req_push/req_full; one is taken when req_push is
//    high and req_full is low. the front measures the move in F_SQX, F_SQY, F_MM and F_DEC
//  - results leave like a queue: rsp_empty low means a stamp waits on rsp_*,
//    rsp_pop takes it. stamps of one request leave in order, last_of_run marks the final
//  - csr_valid/csr_ready writes min_distance (reset 160); zero acts as one.
//    write only while the block is idle; csr_ready is always high
//  - a move passes the front states, then a step-count search (7 bits, states
//    B_MUL1, B_MUL2 and B_CMP for each bit), 16 cordic iterations and two divisions;
//    then its stamps follow one per cycle while the receiver takes them; the very
//    first point skips the search and leaves through B_FIRST
//  - the front takes a request only after the last one is pushed or dropped, and it
//    pushes while the command queue has room; the back starts a move after the last ends
//  - if the receiver stalls, the stamp holds in the output register and the back
//    pauses; the front keeps accepting until the command queue fills
//  - reset clears the stored point, the queues and the csr to 160
`default_nettype none
module trail_stamp_resampler_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic signed [15:0]    req_point_x,
   input  wire logic signed [15:0]    req_point_y,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic signed [15:0]         rsp_stamp_x,
   output logic signed [15:0]         rsp_stamp_y,
   output logic signed [14:0]         rsp_stamp_angle,
   output logic                       rsp_last_of_run,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [15:0]           csr_min_distance
);

   logic [15:0]        min_distance_ff;
   logic [15:0]        eff_dist;
   tsr_pkg::cmd_type   push_cmd, pop_cmd;
   logic               q_push, q_full, q_pop, q_empty;

   // spacing register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= 16'd160;
      end else if (csr_valid && csr_ready) begin
         min_distance_ff <= csr_min_distance;
      end
   end

   // a zero spacing behaves like the smallest spacing
   assign eff_dist = (min_distance_ff == '0) ? 16'd1 : min_distance_ff;

   tsr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .min_dist (eff_dist),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (push_cmd)
   );

   tsr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   tsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .min_dist    (eff_dist),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_data      (pop_cmd),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .stamp_x     (rsp_stamp_x),
      .stamp_y     (rsp_stamp_y),
      .stamp_angle (rsp_stamp_angle),
      .last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire
